@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WFG_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WFG_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/wfg_pkg.sv @@
`default_nettype none

package wfg_pkg;

	localparam int DEF_MAX_PROCESSES = 16;
	localparam int REQ_W = 4;
	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	typedef logic [2:0] status_t;

	localparam status_t ST_GRANTED  = 3'd0;
	localparam status_t ST_RELEASED = 3'd1;
	localparam status_t ST_SAME     = 3'd2;
	localparam status_t ST_DEADLOCK = 3'd3;
	localparam status_t ST_RANGE    = 3'd4;

	typedef struct packed {
		logic re;
		logic we;
	} mem_req_t;

	typedef struct packed {
		logic    idle;
		logic    res_valid;
		status_t status;
	} ctrl_out_t;

endpackage

`default_nettype wire

@@ rtl/core/wait_for_graph_deadlock_guard_unit.sv @@
// Out-of-range and same-process requests need no graph access, a release reads and rewrites one row,
// and a grant or deadlock refusal adds a reachability walk over k <= MAX_PROCESSES graph rows, which
// it reads one row per cycle from the graph memory.
// One request is in flight at a time; the next is accepted once the result has entered the
// output register. Reset clears the graph (per-row valid bits, no sweep) and sets the count to 16.
`default_nettype none
`include "assert_macros.svh"

module wait_for_graph_deadlock_guard_unit import wfg_pkg::*; #(
	parameter int MAX_PROCESSES = DEF_MAX_PROCESSES
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [REQ_W-1:0] requester,
	input  wire logic [REQ_W-1:0] target,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output status_t               status,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_PROCESSES);

	logic [CFG_W-1:0]         process_count_q;
	logic                     out_valid_q;
	status_t                  status_q;
	logic                     start;
	logic                     take;
	ctrl_out_t                cout;
	mem_req_t                 mreq;
	logic [AW-1:0]            raddr;
	logic [AW-1:0]            waddr;
	logic [MAX_PROCESSES-1:0] wdata;
	logic [MAX_PROCESSES-1:0] rdata;

	// count writes only between requests; a pending write goes ahead of a new request
	assign in_ready  = cout.idle & !cfg_valid;
	assign start     = in_valid & in_ready;
	assign take      = !out_valid_q || out_ready;
	assign cfg_ready = cout.idle;
	assign out_valid = out_valid_q;
	assign status    = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_count_q <= CFG_RESET;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				process_count_q <= cfg_data;
			if (cout.res_valid && take)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cout.res_valid && take)
			status_q <= cout.status;
	end

	wfg_ctrl #(
		.MAX_PROCESSES(MAX_PROCESSES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.requester(requester),
		.target   (target),
		.count    (process_count_q),
		.take     (take),
		.cout     (cout),
		.mreq     (mreq),
		.raddr    (raddr),
		.waddr    (waddr),
		.wdata    (wdata),
		.rdata    (rdata)
	);

	wfg_graph_mem #(
		.MAX_PROCESSES(MAX_PROCESSES)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.mreq  (mreq),
		.raddr (raddr),
		.waddr (waddr),
		.wdata (wdata),
		.rdata (rdata)
	);

	`WFG_ASSERT_NXT(a_busy_after_start, clk, arst_n, start, !in_ready, "accepted while busy")
	`WFG_ASSERT_NXT(a_result_loaded, clk, arst_n, cout.res_valid && take, out_valid_q, "result not loaded")
	`WFG_ASSERT_IMP(a_status_code, clk, arst_n, out_valid_q, status_q <= ST_RANGE, "bad status code")

endmodule

`default_nettype wire

@@ rtl/core/wfg_graph_mem.sv @@
`default_nettype none

module wfg_graph_mem import wfg_pkg::*; #(
	parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
	localparam int AW = $clog2(MAX_PROCESSES)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mem_req_t                 mreq,
	input  wire logic [AW-1:0]            raddr,
	input  wire logic [AW-1:0]            waddr,
	input  wire logic [MAX_PROCESSES-1:0] wdata,
	output logic      [MAX_PROCESSES-1:0] rdata
);

	logic [MAX_PROCESSES-1:0] rows [MAX_PROCESSES];
	logic [MAX_PROCESSES-1:0] rdata_q;
	logic [MAX_PROCESSES-1:0] row_valid_q;
	logic                     rvld_q;

	// per-row valid bits stand in for clearing the array at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvld_q      <= 1'b0;
		end else begin
			if (mreq.we)
				row_valid_q[waddr] <= 1'b1;
			if (mreq.re)
				rvld_q <= row_valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.we)
			rows[waddr] <= wdata;
		if (mreq.re)
			rdata_q <= rows[raddr];
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

@@ rtl/core/wfg_ctrl.sv @@
`default_nettype none
`include "assert_macros.svh"

module wfg_ctrl import wfg_pkg::*; #(
	parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
	localparam int AW = $clog2(MAX_PROCESSES)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [REQ_W-1:0]         requester,
	input  wire logic [REQ_W-1:0]         target,
	input  wire logic [CFG_W-1:0]         count,
	input  wire logic                     take,
	output ctrl_out_t                     cout,
	output mem_req_t                      mreq,
	output logic      [AW-1:0]            raddr,
	output logic      [AW-1:0]            waddr,
	output logic      [MAX_PROCESSES-1:0] wdata,
	input  wire logic [MAX_PROCESSES-1:0] rdata
);

	localparam int N  = MAX_PROCESSES;
	localparam int CW = $clog2(N + 1);
	localparam int EW = (CW > CFG_W) ? CW : CFG_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ROW  = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]    state_q, state_d;
	logic          pend_q, pend_d;
	logic [AW-1:0] req_q, req_d;
	logic [AW-1:0] tgt_q, tgt_d;
	logic [N-1:0]  row_q, row_d;
	logic [N-1:0]  seen_q, seen_d;
	logic [N-1:0]  visited_q, visited_d;
	status_t       status_q, status_d;

	logic [EW-1:0] cnt_ext, eff_cnt, req_ext, tgt_ext;
	logic [N-1:0]  active;
	logic [N-1:0]  tgt_oh;
	logic [N-1:0]  seen_n;
	logic [N-1:0]  pend_vec;
	logic [N-1:0]  pick_oh;
	logic [AW-1:0] pick_idx;

	assign cnt_ext = EW'(count);
	assign eff_cnt = (cnt_ext > EW'(N)) ? EW'(N) : cnt_ext;
	assign req_ext = EW'(requester);
	assign tgt_ext = EW'(target);

	always_comb begin
		for (int i = 0; i < N; i++)
			active[i] = (EW'(i) < eff_cnt);
	end

	assign tgt_oh = N'(1) << tgt_q;

	// merge the row returned for the last visited node into the reached set
	assign seen_n   = seen_q | (pend_q ? (rdata & active) : '0);
	assign pend_vec = seen_n & ~visited_q;
	assign pick_oh  = pend_vec & (~pend_vec + N'(1));

	always_comb begin
		pick_idx = '0;
		for (int i = N - 1; i >= 0; i--)
			if (pend_vec[i])
				pick_idx = AW'(i);
	end

	always_comb begin
		state_d   = state_q;
		pend_d    = 1'b0;
		req_d     = req_q;
		tgt_d     = tgt_q;
		row_d     = row_q;
		seen_d    = seen_q;
		visited_d = visited_q;
		status_d  = status_q;
		mreq.re   = 1'b0;
		mreq.we   = 1'b0;
		raddr     = AW'(requester);
		waddr     = req_q;
		wdata     = row_q | tgt_oh;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_d = AW'(requester);
					tgt_d = AW'(target);
					if ((req_ext >= eff_cnt) || (tgt_ext >= eff_cnt)) begin
						status_d = ST_RANGE;
						state_d  = S_DONE;
					end else if (requester == target) begin
						status_d = ST_SAME;
						state_d  = S_DONE;
					end else begin
						mreq.re = 1'b1;
						state_d = S_ROW;
					end
				end
			end
			S_ROW: begin
				if (rdata[tgt_q]) begin
					mreq.we  = 1'b1;
					wdata    = rdata & ~tgt_oh;
					status_d = ST_RELEASED;
					state_d  = S_DONE;
				end else begin
					row_d     = rdata;
					seen_d    = tgt_oh;
					visited_d = '0;
					state_d   = S_WALK;
				end
			end
			S_WALK: begin
				if (seen_n[req_q]) begin
					status_d = ST_DEADLOCK;
					state_d  = S_DONE;
				end else if (pend_vec == '0) begin
					mreq.we  = 1'b1;
					status_d = ST_GRANTED;
					state_d  = S_DONE;
				end else begin
					mreq.re   = 1'b1;
					raddr     = pick_idx;
					visited_d = visited_q | pick_oh;
					seen_d    = seen_n;
					pend_d    = 1'b1;
				end
			end
			S_DONE: begin
				if (take)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q     <= req_d;
		tgt_q     <= tgt_d;
		row_q     <= row_d;
		seen_q    <= seen_d;
		visited_q <= visited_d;
		status_q  <= status_d;
	end

	assign cout.idle      = (state_q == S_IDLE);
	assign cout.res_valid = (state_q == S_DONE);
	assign cout.status    = status_q;

	`WFG_ASSERT_IMP(a_no_rw_overlap, clk, arst_n, mreq.re, !mreq.we, "read and write in one cycle")
	`WFG_ASSERT_NXT(a_write_ends, clk, arst_n, mreq.we, state_q == S_DONE, "write not followed by done")
	`WFG_ASSERT_IMP(a_visited_seen, clk, arst_n, state_q == S_WALK, (visited_q & ~seen_q) == '0, "visited node outside reached set")
	`WFG_ASSERT_NXT(a_pend_read, clk, arst_n, (state_q == S_WALK) && mreq.re, pend_q, "walk read without merge")

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import wfg_pkg::*;

	localparam int NPROC = DEF_MAX_PROCESSES;
	localparam int LONG_STALL = 300;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [REQ_W-1:0] requester;
	logic [REQ_W-1:0] target;
	logic             out_valid;
	logic             out_ready;
	status_t          status;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	wait_for_graph_deadlock_guard_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.requester (requester),
		.target    (target),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the wait-for graph and the process count
	logic [NPROC-1:0] wait_rows [NPROC];
	logic [CFG_W-1:0] proc_count;

	status_t pending_status [$];

	int  mismatches;
	int  results_checked;
	int  count_writes;
	int  status_hits [5];
	bit  valid_gaps_on;
	bit  ready_gaps_on;
	int  long_hold_req;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("timeout: %0d results still pending", pending_status.size());
		$display("TB_ERROR");
		$finish;
	end

	// Applies one request to the shadow graph and returns the status it must produce.
	function automatic status_t grant_decision(input logic [REQ_W-1:0] r,
			input logic [REQ_W-1:0] t);
		int               eff;
		logic [NPROC-1:0] active;
		logic [NPROC-1:0] seen;
		logic [NPROC-1:0] nxt;
		eff = (proc_count > NPROC) ? NPROC : int'(proc_count);
		active = (eff >= NPROC) ? '1 : NPROC'((1 << eff) - 1);
		if (r >= eff || t >= eff)
			return ST_RANGE;
		if (r == t)
			return ST_SAME;
		if (wait_rows[r][t]) begin
			wait_rows[r][t] = 1'b0;
			return ST_RELEASED;
		end
		// edges into inactive processes are masked, but the start itself is always in
		seen = '0;
		seen[t] = 1'b1;
		for (int round = 0; round < NPROC; round++) begin
			nxt = seen;
			for (int i = 0; i < NPROC; i++)
				if (seen[i])
					nxt |= wait_rows[i] & active;
			if (nxt == seen)
				break;
			seen = nxt;
		end
		if (seen[r])
			return ST_DEADLOCK;
		wait_rows[r][t] = 1'b1;
		return ST_GRANTED;
	endfunction

	// Result checker: the transaction completes at the rising edge after this sample.
	always @(negedge clk) begin : result_check
		status_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing expected: status=%0d", status);
			end else begin
				want = pending_status.pop_front();
				results_checked++;
				status_hits[want]++;
				if (status !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("status mismatch: expected %0d, got %0d", want, status);
				end
			end
		end
	end

	initial begin : ready_driver
		int hold;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req != 0) begin
				hold = long_hold_req;
				long_hold_req = 0;
			end else if (hold == 0 && ready_gaps_on && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 12);
			end
			if (hold != 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Called at a rising edge; returns at the edge where the request is taken.
	task automatic send_request(input logic [REQ_W-1:0] r, input logic [REQ_W-1:0] t);
		if (valid_gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		requester <= r;
		target    <= t;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		pending_status.push_back(grant_decision(r, t));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (NPROC + 6) @(posedge clk);
	endtask

	task automatic write_count(input logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		proc_count = v;
		count_writes++;
	endtask

	task automatic send_random(input int n);
		logic [REQ_W-1:0]   r;
		logic [REQ_W-1:0]   t;
		logic [2*REQ_W-1:0] recent [8];
		int                 eff;
		int                 pick;
		eff = (proc_count > NPROC) ? NPROC : int'(proc_count);
		for (int i = 0; i < 8; i++) begin
			r = (eff == 0) ? REQ_W'($urandom) : REQ_W'($urandom_range(0, eff - 1));
			t = (eff == 0) ? REQ_W'($urandom) : REQ_W'($urandom_range(0, eff - 1));
			recent[i] = {r, t};
		end
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 9);
			// replaying a recent pair is what releases edges
			if (pick < 3) begin
				{r, t} = recent[$urandom_range(0, 7)];
			end else if (pick == 3 || eff == 0) begin
				r = REQ_W'($urandom);
				t = REQ_W'($urandom);
			end else begin
				r = REQ_W'($urandom_range(0, eff - 1));
				t = REQ_W'($urandom_range(0, eff - 1));
			end
			recent[$urandom_range(0, 7)] = {r, t};
			send_request(r, t);
		end
	endtask

	task automatic test_basic_ops();
		send_request(4'd0, 4'd15);
		send_request(4'd0, 4'd15);
		send_request(4'd7, 4'd7);
		send_request(4'd15, 4'd15);
		send_request(4'd15, 4'd14);
		send_request(4'd15, 4'd14);
	endtask

	task automatic test_cycle_refusal();
		send_request(4'd1, 4'd2);
		send_request(4'd2, 4'd3);
		send_request(4'd3, 4'd1);
		send_request(4'd3, 4'd4);
		send_request(4'd4, 4'd1);
		send_request(4'd2, 4'd3);
		send_request(4'd3, 4'd1);
	endtask

	task automatic test_count_limits();
		send_request(4'd5, 4'd12);
		send_request(4'd12, 4'd6);
		wait_drained();
		write_count(5'd8);
		send_request(4'd8, 4'd0);
		send_request(4'd0, 4'd8);
		send_request(4'd15, 4'd15);
		// path 5->12->6 runs through an inactive process, so no cycle is seen
		send_request(4'd6, 4'd5);
		wait_drained();
		write_count(5'd16);
		send_request(4'd5, 4'd12);
		send_request(4'd12, 4'd6);
		wait_drained();
		write_count(5'd0);
		send_request(4'd0, 4'd0);
		wait_drained();
		write_count(5'd31);
		send_request(4'd15, 4'd0);
		wait_drained();
		write_count(5'd1);
		send_request(4'd0, 4'd0);
		send_request(4'd1, 4'd0);
		wait_drained();
		write_count(5'd16);
	endtask

	task automatic test_output_backpressure();
		wait_drained();
		long_hold_req = LONG_STALL;
		send_random(6);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		logic [CFG_W-1:0] counts [8];
		int               lengths [8];
		counts  = '{5'd16, 5'd5, 5'd31, 5'd2, 5'd0, 5'd12, 5'd3, 5'd16};
		lengths = '{400, 250, 250, 150, 20, 350, 200, 400};
		for (int p = 0; p < 8; p++) begin
			if (p == 7) begin
				valid_gaps_on = 1'b0;
				ready_gaps_on = 1'b0;
			end
			wait_drained();
			write_count(counts[p]);
			send_random(lengths[p]);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		requester     = '0;
		target        = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		valid_gaps_on = 1'b1;
		ready_gaps_on = 1'b1;
		long_hold_req = 0;
		mismatches    = 0;
		results_checked = 0;
		count_writes  = 0;
		proc_count    = CFG_RESET;
		for (int i = 0; i < 5; i++)
			status_hits[i] = 0;
		for (int i = 0; i < NPROC; i++)
			wait_rows[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_cycle_refusal();
		test_count_limits();
		test_output_backpressure();
		test_random_traffic();
		wait_drained();

		$display("%0d requests checked across %0d process-count writes, with a %0d-cycle output stall",
			results_checked, count_writes, LONG_STALL);
		$display("granted %0d, released %0d, same process %0d, deadlock %0d, out of range %0d",
			status_hits[ST_GRANTED], status_hits[ST_RELEASED], status_hits[ST_SAME],
			status_hits[ST_DEADLOCK], status_hits[ST_RANGE]);
		if (mismatches == 0 && pending_status.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending_status.size());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/wfg_pkg.sv
rtl/core/wfg_graph_mem.sv
rtl/core/wfg_ctrl.sv
rtl/core/wait_for_graph_deadlock_guard_unit.sv
test/tb_top.sv
